>>> hw/rtl/pfng_pkg.sv
// ----------------------------------------------------------------------------
// pfng_pkg: shared types and constants for the peak follower noise gate
// Widths, register indexes and lane control structure.
// ----------------------------------------------------------------------------
package pfng_pkg;

  localparam int CHANNELS    = 2;
  localparam int SAMPLE_BITS = 16;
  // magnitude of the most negative sample needs one more bit
  localparam int MAG_W       = SAMPLE_BITS + 1;
  localparam int ENV_W       = 17;
  localparam int ENV_FRAC    = 16;
  localparam int DECAY_W     = 16;
  localparam int THRESH_W    = 16;
  localparam int ACT_W       = 2;
  localparam int LANE_CMP_W  = 4;
  localparam int PROD_W      = SAMPLE_BITS + ENV_W + 1;
  localparam int DPROD_W     = MAG_W + DECAY_W;
  localparam int TDATA_W     = ((CHANNELS * SAMPLE_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;

  localparam logic [ENV_W-1:0] ENV_ONE = ENV_W'(65536);

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK_STEP  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CH    = 3'd5;

  typedef logic [CHANNELS-1:0][MAG_W-1:0] mag_vec_t;

  typedef struct packed {
    logic active;  // lane takes part in peak and gating
    logic gate;    // gating enabled
  } lane_ctl_t;

endpackage

>>> hw/rtl/pfng_lane.sv
// ----------------------------------------------------------------------------
// pfng_lane: one channel lane
// Magnitude of the sample for the peak search, and the gated sample.
// ----------------------------------------------------------------------------
module pfng_lane (
  input  pfng_pkg::lane_ctl_t                  ctl,
  input  logic signed [pfng_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [pfng_pkg::ENV_W-1:0]           env,
  output logic [pfng_pkg::MAG_W-1:0]           mag,
  output logic signed [pfng_pkg::SAMPLE_BITS-1:0] gated
);
  import pfng_pkg::*;

  logic signed [MAG_W-1:0]  s_ext;
  logic signed [ENV_W:0]    env_s;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] prod_sh;

  assign s_ext = MAG_W'(sample);
  assign mag   = !ctl.active ? '0 : (s_ext < 0) ? MAG_W'(-s_ext) : MAG_W'(s_ext);

  assign env_s   = signed'({1'b0, env});
  assign prod    = PROD_W'(sample) * PROD_W'(env_s);
  // arithmetic shift floors toward minus infinity
  assign prod_sh = prod >>> ENV_FRAC;
  assign gated   = (ctl.active && ctl.gate) ? prod_sh[SAMPLE_BITS-1:0] : sample;

endmodule

>>> hw/rtl/pfng_merge.sv
// ----------------------------------------------------------------------------
// pfng_merge: frame peak merge
// Registers the largest lane magnitude of the frame.
// ----------------------------------------------------------------------------
module pfng_merge (
  input  logic                        clk,
  input  logic                        load,
  input  pfng_pkg::mag_vec_t          mag,
  output logic [pfng_pkg::MAG_W-1:0]  frame_peak_r
);
  import pfng_pkg::*;

  logic [MAG_W-1:0] max_nxt;

  always_comb begin
    max_nxt = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      if (mag[k] > max_nxt) max_nxt = mag[k];
    end
  end

  always_ff @(posedge clk) begin
    if (load) frame_peak_r <= max_nxt;
  end

endmodule

>>> hw/rtl/peak_follower_noise_gate_core.sv
// ----------------------------------------------------------------------------
// peak_follower_noise_gate_core: multichannel noise gate with peak follower
// Lanes find sample magnitudes and gate samples; a merge stage takes the max.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one audio frame per request, all channel samples in in_tdata.
//   out_* : one gated frame per request, same packing.
//   cfg_* : register writes, taken at any edge with cfg_wr_en high; write
//           only while no frame is in flight.
// Order: an accepted frame passes magnitude/merge, peak update, envelope
//   update and gating, then is loaded into the output register, and
//   out_tvalid is set at that same edge.
// Flow: one frame in flight at a time; the peak, envelope and gating
//   products form one dependent chain through the shared state registers.
// Reset: peak and envelope clear to zero, registers take their defaults,
//   the output register empties.
// Stall: a held result waits in the output register while the next frame
//   is accepted; gating of that frame pauses until out_tready frees the slot.
// ----------------------------------------------------------------------------
module peak_follower_noise_gate_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [pfng_pkg::TDATA_W-1:0]          in_tdata,   // sample_0, sample_1
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [pfng_pkg::TDATA_W-1:0]          out_tdata,  // gated_0, gated_1
  input  logic                                  cfg_wr_en,
  input  logic [pfng_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [pfng_pkg::CFG_DATA_W-1:0]       cfg_data
);
  import pfng_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAG  = 3'd1;
  localparam logic [2:0] S_PEAK = 3'd2;
  localparam logic [2:0] S_ENV  = 3'd3;
  localparam logic [2:0] S_GATE = 3'd4;

  logic [2:0] state_r, state_nxt;

  logic                cfg_enable_r;
  logic [THRESH_W-1:0] cfg_thresh_r;
  logic [ENV_W-1:0]    cfg_attack_r;
  logic [ENV_W-1:0]    cfg_release_r;
  logic [DECAY_W-1:0]  cfg_decay_r;
  logic [ACT_W-1:0]    cfg_active_r;

  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] s_r;
  logic [MAG_W-1:0]    peak_r, peak_nxt;
  logic [ENV_W-1:0]    env_r, env_nxt;
  logic                out_valid_r;
  logic [TDATA_W-1:0]  out_data_r, out_data_nxt;

  mag_vec_t            mag;
  logic [MAG_W-1:0]    frame_peak_r;
  logic [CHANNELS-1:0][SAMPLE_BITS-1:0] gated;
  logic [DPROD_W-1:0]  decay_prod;
  logic [ENV_W:0]      env_sum;
  logic                slot_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_enable_r  <= 1'b1;
      cfg_thresh_r  <= THRESH_W'(3277);
      cfg_attack_r  <= ENV_W'(1365);
      cfg_release_r <= ENV_W'(136);
      cfg_decay_r   <= DECAY_W'(65442);
      cfg_active_r  <= ACT_W'(2);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_ENABLE:       cfg_enable_r  <= cfg_data[0];
        REG_THRESHOLD:    cfg_thresh_r  <= cfg_data[THRESH_W-1:0];
        REG_ATTACK_STEP:  cfg_attack_r  <= cfg_data[ENV_W-1:0];
        REG_RELEASE_STEP: cfg_release_r <= cfg_data[ENV_W-1:0];
        REG_DECAY_FACTOR: cfg_decay_r   <= cfg_data[DECAY_W-1:0];
        REG_ACTIVE_CH:    cfg_active_r  <= cfg_data[ACT_W-1:0];
        default: ;
      endcase
    end
  end

  // channel lanes
  for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
    lane_ctl_t ctl;
    assign ctl.active = (LANE_CMP_W'(k) < LANE_CMP_W'(cfg_active_r));
    assign ctl.gate   = cfg_enable_r;
    pfng_lane u_lane (
      .ctl    (ctl),
      .sample (signed'(s_r[k])),
      .env    (env_r),
      .mag    (mag[k]),
      .gated  (gated[k])
    );
  end

  pfng_merge u_merge (
    .clk          (clk),
    .load         (state_r == S_MAG),
    .mag          (mag),
    .frame_peak_r (frame_peak_r)
  );

  assign slot_free  = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign decay_prod = DPROD_W'(peak_r) * DPROD_W'(cfg_decay_r);
  assign env_sum    = (ENV_W + 1)'(env_r) + (ENV_W + 1)'(cfg_attack_r);

  always_comb begin
    state_nxt = state_r;
    peak_nxt  = peak_r;
    env_nxt   = env_r;
    out_data_nxt = '0;
    for (int k = 0; k < CHANNELS; k++) begin
      out_data_nxt[k*SAMPLE_BITS +: SAMPLE_BITS] = gated[k];
    end
    unique case (state_r)
      S_IDLE: if (in_tvalid) state_nxt = S_MAG;
      S_MAG:  state_nxt = S_PEAK;
      S_PEAK: begin
        if (cfg_enable_r) begin
          peak_nxt = (frame_peak_r >= peak_r) ? frame_peak_r
                                              : decay_prod[DECAY_W +: MAG_W];
        end
        state_nxt = S_ENV;
      end
      S_ENV: begin
        if (cfg_enable_r) begin
          if (peak_r >= MAG_W'(cfg_thresh_r)) begin
            env_nxt = (env_sum > (ENV_W + 1)'(ENV_ONE)) ? ENV_ONE : env_sum[ENV_W-1:0];
          end else begin
            env_nxt = (env_r > cfg_release_r) ? env_r - cfg_release_r : '0;
          end
        end
        state_nxt = S_GATE;
      end
      S_GATE: if (slot_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      peak_r      <= '0;
      env_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      peak_r  <= peak_nxt;
      env_r   <= env_nxt;
      if (state_r == S_GATE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      for (int k = 0; k < CHANNELS; k++) begin
        s_r[k] <= in_tdata[k*SAMPLE_BITS +: SAMPLE_BITS];
      end
    end
    if (state_r == S_GATE && slot_free) out_data_r <= out_data_nxt;
  end

  // envelope stays within 0..1.0
  a_env_range: assert property (@(posedge clk) disable iff (!rst_n)
    env_r <= ENV_ONE)
    else $error("envelope above unity");

  // disabled gate leaves the peak follower untouched
  a_peak_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PEAK && !cfg_enable_r) |=> $stable(peak_r))
    else $error("peak changed while disabled");

  // a result appears only after the gating step
  a_out_from_gate: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_GATE))
    else $error("result loaded outside gating step");

endmodule
